// File: sv/qkv_pkg.sv
// Shared types and constants of the quoted key/value tokenizer.
package qkv_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQUAL = 8'h3D;

  localparam logic [7:0] DELIM_RESET    = 8'h20;
  localparam logic       PAD_EN_RESET   = 1'b0;
  localparam logic [7:0] PAD_CHAR_RESET = 8'h20;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIMITER  = 2'd0,
    CFG_PAD_ENABLE = 2'd1,
    CFG_PAD_CHAR   = 2'd2
  } qkv_cfg_idx_t;

  typedef enum logic [3:0] {
    PH_KEY   = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_GAP   = 4'b1000
  } qkv_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } qkv_in_t;

  typedef struct packed {
    logic       char_valid;
    logic       part;
    logic [7:0] out_char;
    logic       pair_done;
  } qkv_out_t;

  typedef struct packed {
    qkv_phase_t phase;
    logic       in_quotes;
    logic       pair_open;
  } qkv_state_t;

  typedef struct packed {
    logic [7:0] delimiter;
    logic       pad_enable;
    logic [7:0] pad_char;
  } qkv_cfg_t;

endpackage

// File: sv/qkv_step.sv
// Next-state and result logic for one byte of the tokenizer.
module qkv_step (
  input  qkv_pkg::qkv_state_t state,
  input  qkv_pkg::qkv_cfg_t   cfg,
  input  qkv_pkg::qkv_in_t    item,
  output qkv_pkg::qkv_state_t state_nxt,
  output qkv_pkg::qkv_out_t   result,
  output logic                has_result
);

  logic is_delim;
  logic is_pad;
  logic is_equal;
  logic is_quote;
  logic do_key;
  logic do_skip;
  logic do_value;

  assign is_delim = (item.ch == cfg.delimiter);
  assign is_pad   = cfg.pad_enable && (item.ch == cfg.pad_char);
  assign is_equal = (item.ch == qkv_pkg::CH_EQUAL);
  assign is_quote = (item.ch == qkv_pkg::CH_QUOTE);

  always_comb begin
    state_nxt = state;
    result    = '0;
    do_key    = 1'b0;
    do_skip   = 1'b0;
    do_value  = 1'b0;

    unique case (state.phase)
      qkv_pkg::PH_KEY:   do_key = 1'b1;
      qkv_pkg::PH_SKIP:  do_skip = 1'b1;
      qkv_pkg::PH_VALUE: do_value = 1'b1;
      qkv_pkg::PH_GAP: begin
        if (!is_delim) begin
          state_nxt.phase = qkv_pkg::PH_KEY;
          do_key = 1'b1;
        end
      end
      default: state_nxt.phase = qkv_pkg::PH_KEY;
    endcase

    // A terminating byte of the key is judged again as in the skip phase.
    if (do_key) begin
      state_nxt.pair_open = 1'b1;
      if (is_equal || (!state.in_quotes && (is_delim || is_pad))) begin
        do_skip = 1'b1;
      end else if (is_quote) begin
        state_nxt.in_quotes = ~state.in_quotes;
      end else begin
        result.char_valid = 1'b1;
        result.part       = 1'b0;
        result.out_char   = item.ch;
      end
    end

    // Padding is tested before the delimiter, so it wins when both match.
    if (do_skip) begin
      if (is_equal || is_pad) begin
        state_nxt.phase = qkv_pkg::PH_SKIP;
      end else if (is_delim) begin
        result.pair_done    = 1'b1;
        state_nxt.phase     = qkv_pkg::PH_GAP;
        state_nxt.pair_open = 1'b0;
      end else begin
        state_nxt.phase = qkv_pkg::PH_VALUE;
        do_value = 1'b1;
      end
    end

    if (do_value) begin
      if (!state.in_quotes && is_delim) begin
        result.pair_done    = 1'b1;
        state_nxt.phase     = qkv_pkg::PH_GAP;
        state_nxt.pair_open = 1'b0;
      end else if (is_quote) begin
        state_nxt.in_quotes = ~state.in_quotes;
      end else begin
        result.char_valid = 1'b1;
        result.part       = 1'b1;
        result.out_char   = item.ch;
      end
    end

    // The end of the text closes an open pair and restarts the parser.
    if (item.last) begin
      result.pair_done    = result.pair_done | state_nxt.pair_open;
      state_nxt.phase     = qkv_pkg::PH_KEY;
      state_nxt.in_quotes = 1'b0;
      state_nxt.pair_open = 1'b0;
    end
  end

  assign has_result = result.char_valid | result.pair_done;

endmodule

// File: sv/quoted_key_value_tokenizer.sv
// Top level of the quoted key/value tokenizer: channels, registers and config.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    qkv_in_t  {ch, last}
//   out_     output     out_valid/out_stall  qkv_out_t {char_valid, part, out_char, pair_done}
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// The block takes one item per clock cycle unless a waiting result is held by
// out_stall. An item is held in the input register and its result, if it has
// one, is then registered in the output register. The parser state lives next
// to the per-byte logic and is updated as each item moves on.
// rst_n is synchronous and active low; it clears the handshake and parser
// state and restores the reset values of the configuration registers.
// While out_stall holds a waiting result, in_stall rises only once the input
// register is also full.
module quoted_key_value_tokenizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  qkv_pkg::qkv_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output qkv_pkg::qkv_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [qkv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qkv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Input register.
  logic              in_v_r;
  qkv_pkg::qkv_in_t  in_r;

  // Output register.
  logic              out_v_r;
  logic              out_v_nxt;
  qkv_pkg::qkv_out_t out_r;

  // Parser state and configuration.
  qkv_pkg::qkv_state_t state_r;
  qkv_pkg::qkv_state_t state_nxt;
  qkv_pkg::qkv_cfg_t   cfg_r;

  qkv_pkg::qkv_out_t step_result;
  logic              step_has_result;
  logic              advance;
  logic              process;

  // The output register can take a new result when it is empty or being drained.
  assign advance  = !out_v_r || !out_stall;
  // The item in the input register is consumed this cycle.
  assign process  = in_v_r && advance;
  assign in_stall = in_v_r && !advance;

  qkv_step u_step (
    .state      (state_r),
    .cfg        (cfg_r),
    .item       (in_r),
    .state_nxt  (state_nxt),
    .result     (step_result),
    .has_result (step_has_result)
  );

  always_comb begin
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = process && step_has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '{phase: qkv_pkg::PH_KEY, in_quotes: 1'b0, pair_open: 1'b0};
    end else begin
      out_v_r <= out_v_nxt;
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (process) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
    if (process && step_has_result) begin
      out_r <= step_result;
    end
  end

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter  <= qkv_pkg::DELIM_RESET;
      cfg_r.pad_enable <= qkv_pkg::PAD_EN_RESET;
      cfg_r.pad_char   <= qkv_pkg::PAD_CHAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qkv_pkg::CFG_DELIMITER:  cfg_r.delimiter  <= cfg_wdata;
        qkv_pkg::CFG_PAD_ENABLE: cfg_r.pad_enable <= cfg_wdata[0];
        qkv_pkg::CFG_PAD_CHAR:   cfg_r.pad_char   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // The phase register always holds exactly one phase.
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r.phase))
    else $error("parser phase is not one-hot");

  // A result that leaves the block always carries a byte or a pair end.
  a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.char_valid || out_r.pair_done))
    else $error("empty result in the output register");

  // The last byte of a text returns the parser to its reset state.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (process && in_r.last) |=>
      (state_r.phase == qkv_pkg::PH_KEY && !state_r.in_quotes && !state_r.pair_open))
    else $error("parser not restarted after the last byte");

  // Ending a pair leaves no pair open.
  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (process && step_result.pair_done) |=> !state_r.pair_open)
    else $error("pair still open after pair end");

endmodule
